FILE: src/assert_macros.svh
// Assertion macros shared by the pulse rate detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising aclk edge, ignored while aresetn is low.
`define PRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising aclk edge, reset included.
`define PRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/prd_pkg.sv
// Package with the constants, codes and types of the pulse rate detector.
`default_nettype none

package prd_pkg;

    // Fixed block dimensions.
    localparam int AVG_LEN      = 8;
    localparam int AVG_SHIFT    = $clog2(AVG_LEN);
    localparam int WINDOW_LEN   = 9;
    localparam int WIN_AW       = $clog2(WINDOW_LEN + 1);
    localparam int COUNT_PERIOD = 150;
    localparam int DEBOUNCE_LEN = 5;
    localparam int BAR_STEPS    = 8;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + AVG_SHIFT;
    localparam int CNT_W    = AVG_SHIFT;
    localparam int PCT_W    = 7;
    localparam int SCALE_W  = 4;
    localparam int PEAK_W   = 7;
    localparam int PERIOD_W = 8;
    localparam int RATE_W   = 9;
    localparam int BAR_W    = 8;
    localparam int KSTEP_W  = 4;
    localparam int PROD_W   = SAMPLE_W + PCT_W;
    localparam int CFG_AW   = 8;
    localparam int CFG_DW   = 16;

    // Saturation limits and multipliers of the normalised level tests.
    localparam logic [PEAK_W-1:0]   PEAK_MAX  = 7'd127;
    localparam logic [RATE_W-1:0]   RATE_MAX  = 9'd300;
    localparam logic [PCT_W-1:0]    PCT_SCALE = 7'd100;
    localparam logic [PCT_W-1:0]    BAR_SCALE = 7'd9;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'hffff;

    // Register reset values.
    localparam logic [15:0]        FLAT_RST  = 16'd590;
    localparam logic [PCT_W-1:0]   RISE_RST  = 7'd55;
    localparam logic [PCT_W-1:0]   FALL_RST  = 7'd45;
    localparam logic [SCALE_W-1:0] SCALE_RST = 4'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        CFG_FLAT_THRESHOLD = 8'd0,
        CFG_RISE_PERCENT   = 8'd1,
        CFG_FALL_PERCENT   = 8'd2,
        CFG_RATE_SCALE     = 8'd3
    } cfg_index_t;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_UPD  = 8'b0000_0010,
        ST_SCAN = 8'b0000_0100,
        ST_EVAL = 8'b0000_1000,
        ST_PEAK = 8'b0001_0000,
        ST_RATE = 8'b0010_0000,
        ST_BAR  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    // Operands of the shared cross-multiply compare unit: a*ma against b*mb.
    typedef struct packed {
        logic [SAMPLE_W-1:0] a;
        logic [PCT_W-1:0]    ma;
        logic [SAMPLE_W-1:0] b;
        logic [PCT_W-1:0]    mb;
    } cmp_op_t;

    typedef struct packed {
        logic gt;
        logic lt;
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: src/prd_cmp.sv
// Shared cross-multiply compare unit of the pulse rate detector.
`default_nettype none

module prd_cmp (
    input  wire prd_pkg::cmp_op_t op,
    output prd_pkg::cmp_res_t     res
);
    import prd_pkg::*;

    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;

    // Two narrow products and one magnitude compare.
    always_comb begin
        lhs    = PROD_W'(op.a) * PROD_W'(op.ma);
        rhs    = PROD_W'(op.b) * PROD_W'(op.mb);
        res.gt = lhs > rhs;
        res.lt = lhs < rhs;
    end

endmodule

`default_nettype wire

FILE: src/prd_debounce.sv
// Button debouncer and display mode toggle of the pulse rate detector.
`default_nettype none

module prd_debounce (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic tick,
    input  wire logic button,
    output logic      mode
);
    import prd_pkg::*;

    logic [DEBOUNCE_LEN-1:0] history_reg, history_next;
    logic                    toggled_reg, toggled_next;
    logic                    mode_reg, mode_next;

    // A stable low history toggles the mode once; a stable high history re-arms it.
    always_comb begin
        history_next = history_reg;
        toggled_next = toggled_reg;
        mode_next    = mode_reg;
        if (tick) begin
            history_next = {history_reg[DEBOUNCE_LEN-2:0], button};
            if (!toggled_reg && history_next == '0) begin
                mode_next    = ~mode_reg;
                toggled_next = 1'b1;
            end else if (toggled_reg && history_next == '1) begin
                toggled_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg <= '1;
            toggled_reg <= 1'b0;
            mode_reg    <= 1'b1;
        end else begin
            history_reg <= history_next;
            toggled_reg <= toggled_next;
            mode_reg    <= mode_next;
        end
    end

    assign mode = mode_reg;

endmodule

`default_nettype wire

FILE: src/pulse_rate_detector_top.sv
// Top level of the pulse rate detector: sequencer, averaging window and outputs.
//
//   channel  direction  handshake             payload
//   s_       in         s_valid / s_ready     s_sample, s_button
//   m_       out        m_valid / m_ready     m_status, m_display_mode, m_bar_column,
//                                             m_heart_rate, m_peak_active
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item that does not complete an average is accepted in the idle state and gives no result.
// An item that completes an average keeps s_ready low through one window update, a rescan
// of the whole window when an extreme leaves the window, and the flat check; a reading that
// is not flat adds the peak and rate steps and 1 to 8 compare steps for the bar column. The
// result then waits in the hand-off state until the output register is free. Reset is
// synchronous; the window valid bits clear at once, with no clearing pass. cfg_ready is high.
`default_nettype none

module pulse_rate_detector_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [prd_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic                        s_button,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_status,
    output logic                             m_display_mode,
    output logic [prd_pkg::BAR_W-1:0]        m_bar_column,
    output logic [prd_pkg::RATE_W-1:0]       m_heart_rate,
    output logic                             m_peak_active,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [prd_pkg::CFG_AW-1:0]  cfg_index,
    input  wire logic [prd_pkg::CFG_DW-1:0]  cfg_data
);
    import prd_pkg::*;

    `include "assert_macros.svh"

    // Configuration registers.
    logic [15:0]        flat_reg;
    logic [PCT_W-1:0]   rise_reg;
    logic [PCT_W-1:0]   fall_reg;
    logic [SCALE_W-1:0] scale_reg;

    // Sequencer and datapath registers.
    state_t              state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [WIN_AW-1:0]   widx_reg, widx_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic                rescan_max_reg, rescan_max_next;
    logic                rescan_min_reg, rescan_min_next;
    logic [WIN_AW-1:0]   cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] range_reg, range_next;
    logic [SAMPLE_W-1:0] d_reg, d_next;
    logic                peak_reg, peak_next;
    logic [PEAK_W-1:0]   total_reg, total_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [KSTEP_W-1:0]  k_reg, k_next;
    logic                status_reg, status_next;
    logic [BAR_W-1:0]    bar_reg, bar_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic                o_status_reg, o_mode_reg, o_peak_reg;
    logic [BAR_W-1:0]    o_bar_reg;
    logic [RATE_W-1:0]   o_rate_reg;
    logic                o_load;

    // Window memory with registered read port and flip-flop valid bits.
    logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] wvalid_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [WIN_AW-1:0]   rd_addr;
    logic                mem_we;

    logic      accept;
    logic      mode;
    cmp_op_t   cmp_op;
    cmp_res_t  cmp_res;
    logic [SUM_W-1:0]           sum_ext;
    logic [SCALE_W+PEAK_W-1:0]  rate_prod;
    logic [PERIOD_W-1:0]        period_inc;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    prd_debounce u_debounce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (accept),
        .button  (s_button),
        .mode    (mode)
    );

    prd_cmp u_cmp (
        .op  (cmp_op),
        .res (cmp_res)
    );

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flat_reg  <= FLAT_RST;
            rise_reg  <= RISE_RST;
            fall_reg  <= FALL_RST;
            scale_reg <= SCALE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FLAT_THRESHOLD: flat_reg  <= cfg_data;
                CFG_RISE_PERCENT:   rise_reg  <= cfg_data[PCT_W-1:0];
                CFG_FALL_PERCENT:   fall_reg  <= cfg_data[PCT_W-1:0];
                CFG_RATE_SCALE:     scale_reg <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // The read port serves the overwritten entry in IDLE and the rescan in SCAN.
    always_comb begin
        rd_addr = widx_reg;
        if (state_reg == ST_SCAN) begin
            rd_addr = (cnt_reg < WIN_AW'(WINDOW_LEN)) ? cnt_reg : '0;
        end
    end

    assign mem_we = (state_reg == ST_UPD);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[widx_reg] <= avg_reg;
        end
        rd_data_reg  <= win_mem[rd_addr];
        rd_valid_reg <= wvalid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg <= '0;
        end else if (mem_we) begin
            wvalid_reg[widx_reg] <= 1'b1;
        end
    end

    // Shared compare unit operands: peak test, then bar steps.
    always_comb begin
        cmp_op.a  = d_reg;
        cmp_op.b  = range_reg;
        cmp_op.ma = PCT_SCALE;
        cmp_op.mb = peak_reg ? fall_reg : rise_reg;
        if (state_reg == ST_BAR) begin
            cmp_op.ma = BAR_SCALE;
            cmp_op.mb = PCT_W'(k_reg);
        end
    end

    assign sum_ext    = sum_reg + SUM_W'(s_sample);
    assign rate_prod  = (SCALE_W+PEAK_W)'(scale_reg) * (SCALE_W+PEAK_W)'(total_reg);
    assign period_inc = period_reg + 1'b1;
    assign o_load     = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        avg_next        = avg_reg;
        widx_next       = widx_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        rescan_max_next = rescan_max_reg;
        rescan_min_next = rescan_min_reg;
        cnt_next        = cnt_reg;
        range_next      = range_reg;
        d_next          = d_reg;
        peak_next       = peak_reg;
        total_next      = total_reg;
        period_next     = period_reg;
        rate_next       = rate_reg;
        k_next          = k_reg;
        status_next     = status_reg;
        bar_next        = bar_reg;

        unique case (state_reg)
            // Accumulate samples; the last one of a group forms the average.
            ST_IDLE: begin
                if (accept) begin
                    if (count_reg == CNT_W'(AVG_LEN - 1)) begin
                        avg_next   = sum_ext[SUM_W-1:AVG_SHIFT];
                        sum_next   = '0;
                        count_next = '0;
                        state_next = ST_UPD;
                    end else begin
                        sum_next   = sum_ext;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            // Overwrite the oldest entry and update the extremes.
            ST_UPD: begin
                rescan_max_next = 1'b0;
                rescan_min_next = 1'b0;
                widx_next = (widx_reg == WIN_AW'(WINDOW_LEN - 1)) ? '0 : widx_reg + 1'b1;
                if (avg_reg > max_reg) begin
                    max_next = avg_reg;
                end else if (rd_valid_reg && rd_data_reg == max_reg) begin
                    max_next        = '0;
                    rescan_max_next = 1'b1;
                end
                if (avg_reg < min_reg) begin
                    min_next = avg_reg;
                end else if (rd_valid_reg && rd_data_reg == min_reg) begin
                    min_next        = FULL_SCALE;
                    rescan_min_next = 1'b1;
                end
                cnt_next   = '0;
                state_next = (rescan_max_next || rescan_min_next) ? ST_SCAN : ST_EVAL;
            end
            // Rescan the valid entries; the read port is registered, so read data trails the address.
            ST_SCAN: begin
                if (cnt_reg != '0 && rd_valid_reg) begin
                    if (rescan_max_reg && rd_data_reg > max_reg) begin
                        max_next = rd_data_reg;
                    end
                    if (rescan_min_reg && rd_data_reg < min_reg) begin
                        min_next = rd_data_reg;
                    end
                end
                if (cnt_reg == WIN_AW'(WINDOW_LEN)) begin
                    state_next = ST_EVAL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            // Flat check, spread and offset of the average.
            ST_EVAL: begin
                range_next = max_reg - min_reg;
                d_next     = (avg_reg >= min_reg) ? avg_reg - min_reg : '0;
                if (max_reg < min_reg || range_next < flat_reg) begin
                    status_next = 1'b1;
                    bar_next    = '0;
                    state_next  = ST_DONE;
                end else begin
                    status_next = 1'b0;
                    state_next  = ST_PEAK;
                end
            end
            // Peak hysteresis.
            ST_PEAK: begin
                if (!peak_reg && cmp_res.gt) begin
                    peak_next = 1'b1;
                    if (total_reg < PEAK_MAX) begin
                        total_next = total_reg + 1'b1;
                    end
                end else if (peak_reg && cmp_res.lt) begin
                    peak_next = 1'b0;
                end
                state_next = ST_RATE;
            end
            // Counting period and heart rate.
            ST_RATE: begin
                period_next = period_inc;
                if (period_inc >= PERIOD_W'(COUNT_PERIOD)) begin
                    rate_next   = (rate_prod > (SCALE_W+PEAK_W)'(RATE_MAX))
                                  ? RATE_MAX : rate_prod[RATE_W-1:0];
                    period_next = '0;
                    total_next  = '0;
                end
                k_next     = KSTEP_W'(1);
                state_next = ST_BAR;
            end
            // Bar level: first k with d*9 <= k*range.
            ST_BAR: begin
                if (!cmp_res.gt) begin
                    bar_next   = (BAR_W'(1) << (k_reg - 1'b1)) - 1'b1;
                    state_next = ST_DONE;
                end else if (k_reg == KSTEP_W'(BAR_STEPS)) begin
                    bar_next   = '1;
                    state_next = ST_DONE;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            // Hand the item to the output register.
            ST_DONE: begin
                if (o_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sum_reg    <= '0;
            count_reg  <= '0;
            widx_reg   <= '0;
            max_reg    <= '0;
            min_reg    <= FULL_SCALE;
            peak_reg   <= 1'b0;
            total_reg  <= '0;
            period_reg <= '0;
            rate_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            widx_reg   <= widx_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
            peak_reg   <= peak_next;
            total_reg  <= total_next;
            period_reg <= period_next;
            rate_reg   <= rate_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg        <= avg_next;
        rescan_max_reg <= rescan_max_next;
        rescan_min_reg <= rescan_min_next;
        cnt_reg        <= cnt_next;
        range_reg      <= range_next;
        d_reg          <= d_next;
        k_reg          <= k_next;
        status_reg     <= status_next;
        bar_reg        <= bar_next;
    end

    // Output register and its valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (o_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_status_reg <= status_reg;
            o_mode_reg   <= mode;
            o_bar_reg    <= bar_reg;
            o_rate_reg   <= rate_reg;
            o_peak_reg   <= peak_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = o_status_reg;
    assign m_display_mode = o_mode_reg;
    assign m_bar_column   = o_bar_reg;
    assign m_heart_rate   = o_rate_reg;
    assign m_peak_active  = o_peak_reg;

    // A new result only ever comes out of the hand-off state.
    `PRD_ASSERT(a_result_from_done, $rose(m_valid) |-> $past(state_reg == ST_DONE),
                "result appeared outside the hand-off state")
    // After the update and rescan the window holds a valid entry, so max is not below min.
    `PRD_ASSERT(a_extremes_ordered, (state_reg == ST_EVAL) |-> (max_reg >= min_reg),
                "window maximum below minimum at evaluation")
    // The bar step stays within its eight levels.
    `PRD_ASSERT(a_bar_step_range,
                (state_reg == ST_BAR) |-> (k_reg != '0 && k_reg <= KSTEP_W'(BAR_STEPS)),
                "bar step out of range")
    // Never more than one result held at a time: loading needs an empty or draining register.
    `PRD_ASSERT(a_no_overwrite, (m_valid && !m_ready) |=> !$past(o_load),
                "output register overwritten while stalled")

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the pulse rate detector.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prd_pkg::*;

    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int CFG_FIRST_UNUSED = int'(CFG_RATE_SCALE) + 1;
    localparam int CFG_INDEX_TOP    = (1 << CFG_AW) - 1;
    localparam int SAMPLE_TOP       = (1 << SAMPLE_W) - 1;

    // One photodiode tick as offered on the input channel.
    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic                button;
    } tick_t;

    // One reading as seen on the result channel.
    typedef struct packed {
        logic              status;
        logic              display_mode;
        logic [BAR_W-1:0]  bar_column;
        logic [RATE_W-1:0] heart_rate;
        logic              peak_active;
    } pulse_reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample = '0;
    logic                s_button = 1'b1;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_status;
    logic                m_display_mode;
    logic [BAR_W-1:0]    m_bar_column;
    logic [RATE_W-1:0]   m_heart_rate;
    logic                m_peak_active;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_AW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;

    pulse_rate_detector_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_button       (s_button),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_display_mode (m_display_mode),
        .m_bar_column   (m_bar_column),
        .m_heart_rate   (m_heart_rate),
        .m_peak_active  (m_peak_active),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    tick_t          pending_ticks[$];
    pulse_reading_t expected_readings[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  quiet_run = 1'b0;
    bit  long_hold_req = 1'b0;
    int  press_left = 0;

    // Register copies kept by the predictor.
    logic [15:0]        flat_thr;
    logic [PCT_W-1:0]   rise_pct;
    logic [PCT_W-1:0]   fall_pct;
    logic [SCALE_W-1:0] bpm_scale;

    // Detector state kept by the predictor.
    logic [SUM_W-1:0]        acc_sum;
    int                      acc_count;
    logic [SAMPLE_W-1:0]     avg_ring[WINDOW_LEN];
    bit                      ring_used[WINDOW_LEN];
    int                      ring_pos;
    logic [SAMPLE_W-1:0]     ring_max;
    logic [SAMPLE_W-1:0]     ring_min;
    logic                    in_peak;
    logic [PEAK_W-1:0]       peaks_seen;
    logic [PERIOD_W-1:0]     avgs_seen;
    logic [RATE_W-1:0]       bpm_held;
    logic                    bar_mode;
    logic [DEBOUNCE_LEN-1:0] press_hist;
    logic                    press_latched;

    // Put the predictor into its power-up state.
    task automatic clear_pulse_model();
        flat_thr      = FLAT_RST;
        rise_pct      = RISE_RST;
        fall_pct      = FALL_RST;
        bpm_scale     = SCALE_RST;
        acc_sum       = '0;
        acc_count     = 0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            avg_ring[i]  = '0;
            ring_used[i] = 1'b0;
        end
        ring_pos      = 0;
        ring_max      = '0;
        ring_min      = FULL_SCALE;
        in_peak       = 1'b0;
        peaks_seen    = '0;
        avgs_seen     = '0;
        bpm_held      = '0;
        bar_mode      = 1'b1;
        press_hist    = '1;
        press_latched = 1'b0;
    endtask

    // Largest or smallest average over the occupied window slots.
    function automatic logic [SAMPLE_W-1:0] ring_extreme(input bit want_max);
        logic [SAMPLE_W-1:0] best;
        best = want_max ? '0 : FULL_SCALE;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (ring_used[i]) begin
                if (want_max ? (avg_ring[i] > best) : (avg_ring[i] < best))
                    best = avg_ring[i];
            end
        end
        return best;
    endfunction

    // Bar column: the first step k with offset*9 <= k*spread picks the mask.
    function automatic logic [BAR_W-1:0] level_bar(input longint unsigned offset,
                                                   input longint unsigned spread);
        logic [BAR_W-1:0] mask;
        bit               found;
        mask  = 8'hff;
        found = 1'b0;
        for (int k = 1; k <= BAR_STEPS; k++) begin
            if (!found && offset * longint'(BAR_SCALE) <= longint'(k) * spread) begin
                mask  = BAR_W'((1 << (k - 1)) - 1);
                found = 1'b1;
            end
        end
        return mask;
    endfunction

    // Advance the predictor by one accepted tick and queue the reading it causes.
    task automatic track_pulse(input logic [SAMPLE_W-1:0] smp, input logic btn);
        logic [SAMPLE_W-1:0] avg;
        logic [SAMPLE_W-1:0] old_val;
        bit                  old_ok;
        int                  slot;
        int                  rate_prod;
        longint unsigned     spread;
        longint unsigned     offset;
        pulse_reading_t      rd;

        // Debounce: a full run of zeros toggles the mode once, all ones re-arms.
        press_hist = {press_hist[DEBOUNCE_LEN-2:0], btn};
        if (!press_latched && press_hist == '0) begin
            bar_mode      = ~bar_mode;
            press_latched = 1'b1;
        end else if (press_latched && press_hist == '1) begin
            press_latched = 1'b0;
        end

        acc_sum   = acc_sum + smp;
        acc_count = acc_count + 1;
        if (acc_count >= AVG_LEN) begin
            avg       = SAMPLE_W'(acc_sum / AVG_LEN);
            acc_sum   = '0;
            acc_count = 0;

            slot            = ring_pos;
            old_val         = avg_ring[slot];
            old_ok          = ring_used[slot];
            avg_ring[slot]  = avg;
            ring_used[slot] = 1'b1;
            ring_pos        = (slot + 1) % WINDOW_LEN;

            // Rescan an extreme only when its holder was just overwritten.
            if (avg > ring_max)
                ring_max = avg;
            else if (old_ok && old_val == ring_max)
                ring_max = ring_extreme(1'b1);
            if (avg < ring_min)
                ring_min = avg;
            else if (old_ok && old_val == ring_min)
                ring_min = ring_extreme(1'b0);

            rd.display_mode = bar_mode;
            if (ring_max < ring_min || (int'(ring_max) - int'(ring_min)) < int'(flat_thr)) begin
                rd.status     = 1'b1;
                rd.bar_column = '0;
            end else begin
                spread = longint'(ring_max) - longint'(ring_min);
                offset = (avg >= ring_min) ? longint'(avg) - longint'(ring_min) : 0;
                if (!in_peak && offset * longint'(PCT_SCALE) > longint'(rise_pct) * spread) begin
                    in_peak = 1'b1;
                    if (peaks_seen < PEAK_MAX)
                        peaks_seen = peaks_seen + 1'b1;
                end else if (in_peak &&
                             offset * longint'(PCT_SCALE) < longint'(fall_pct) * spread) begin
                    in_peak = 1'b0;
                end
                avgs_seen = avgs_seen + 1'b1;
                if (avgs_seen >= COUNT_PERIOD) begin
                    rate_prod  = int'(bpm_scale) * int'(peaks_seen);
                    bpm_held   = (rate_prod > int'(RATE_MAX)) ? RATE_MAX : RATE_W'(rate_prod);
                    avgs_seen  = '0;
                    peaks_seen = '0;
                end
                rd.status     = 1'b0;
                rd.bar_column = level_bar(offset, spread);
            end
            rd.heart_rate  = bpm_held;
            rd.peak_active = in_peak;
            expected_readings.push_back(rd);
        end
    endtask

    // Compare one field of a reading and report a mismatch.
    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Input driver: offers queued ticks, with random gaps after accepted items.
    always @(posedge aclk) begin : tick_driver
        tick_t tk;
        int    gap_left;
        int    gap_chance;
        int    taken;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   = 0;
            gap_chance = 0;
            taken      = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_pulse(s_sample, s_button);
                taken++;
                if (taken % 128 == 0)
                    gap_chance = ($urandom_range(0, 1) == 1) ? 35 : 0;
            end
            if (s_valid && !s_ready) begin
                // Item still waiting: hold valid and payload.
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                tk = pending_ticks.pop_front();
                s_valid  <= 1'b1;
                s_sample <= tk.value;
                s_button <= tk.button;
                if (!quiet_run && $urandom_range(0, 99) < gap_chance)
                    gap_left = $urandom_range(1, 5);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted reading and paces m_ready.
    always @(posedge aclk) begin : reading_monitor
        pulse_reading_t want;
        int             hold_left;
        int             stall_chance;
        int             seen;
        logic           ready_nxt;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            hold_left    = 0;
            stall_chance = 30;
            seen         = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen++;
                if (seen % 16 == 0)
                    stall_chance = ($urandom_range(0, 1) == 1) ? 40 : 0;
                if (expected_readings.size() == 0) begin
                    error_count++;
                    $display("%0t: reading with no expectation, expected none, actual %h",
                             $time, {m_status, m_display_mode, m_bar_column,
                                     m_heart_rate, m_peak_active});
                end else begin
                    want = expected_readings.pop_front();
                    check_field("status", 16'(want.status), 16'(m_status));
                    check_field("display_mode", 16'(want.display_mode), 16'(m_display_mode));
                    check_field("bar_column", 16'(want.bar_column), 16'(m_bar_column));
                    check_field("heart_rate", 16'(want.heart_rate), 16'(m_heart_rate));
                    check_field("peak_active", 16'(want.peak_active), 16'(m_peak_active));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end else if (long_hold_req) begin
                // Long back-pressure so the block fills up and stalls its input.
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                ready_nxt     = 1'b0;
            end else if (!quiet_run && $urandom_range(0, 99) < stall_chance) begin
                hold_left = $urandom_range(1, 5) - 1;
                ready_nxt = 1'b0;
            end else begin
                ready_nxt = 1'b1;
            end
            m_ready <= ready_nxt;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Raw button stream: mostly released, with bounces and real presses.
    function automatic logic next_button();
        if (press_left > 0) begin
            press_left--;
            return 1'b0;
        end
        if ($urandom_range(0, 99) < 3) begin
            press_left = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3)
                                                     : $urandom_range(4, 13);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_tick(input logic [SAMPLE_W-1:0] value, input logic btn);
        tick_t tk;
        tk.value  = value;
        tk.button = btn;
        pending_ticks.push_back(tk);
    endtask

    // Triangle pulse train: n_avg averages, each from 8 noisy samples around the level.
    task automatic push_segment(input int n_avg, input int base, input int amp,
                                input int period, input int noise);
        int half;
        int ph;
        int lvl;
        int v;
        half = (period / 2 > 0) ? period / 2 : 1;
        for (int a = 0; a < n_avg; a++) begin
            ph  = a % period;
            lvl = base + ((ph < half) ? (amp * ph) / half : (amp * (period - ph)) / half);
            for (int s = 0; s < AVG_LEN; s++) begin
                v = lvl + int'($urandom_range(0, 2 * noise)) - noise;
                if (v < 0)
                    v = 0;
                if (v > SAMPLE_TOP)
                    v = SAMPLE_TOP;
                push_tick(SAMPLE_W'(v), next_button());
            end
        end
    endtask

    // Unstructured ticks, not aligned to the averaging boundary.
    task automatic push_noise(input int n_items);
        for (int i = 0; i < n_items; i++)
            push_tick(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), 1'($urandom_range(0, 1)));
    endtask

    // Register write over the configuration channel; the copy updates on acceptance.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FLAT_THRESHOLD: flat_thr  = data;
            CFG_RISE_PERCENT:   rise_pct  = data[PCT_W-1:0];
            CFG_FALL_PERCENT:   fall_pct  = data[PCT_W-1:0];
            CFG_RATE_SCALE:     bpm_scale = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every tick is taken and every reading checked, then let the block settle.
    task automatic drain_and_settle();
        while (pending_ticks.size() != 0 || s_valid || expected_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random register setting, with junk in the unused upper bits of the narrow registers.
    task automatic random_config();
        int rise;
        int fall;
        rise = $urandom_range(20, 90);
        fall = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 100) : $urandom_range(0, rise);
        write_reg(CFG_FLAT_THRESHOLD, ($urandom_range(0, 99) < 10)
                  ? CFG_DW'($urandom_range(0, SAMPLE_TOP)) : CFG_DW'($urandom_range(0, 3000)));
        write_reg(CFG_RISE_PERCENT, {9'($urandom), 7'(rise)});
        write_reg(CFG_FALL_PERCENT, {9'($urandom), 7'(fall)});
        write_reg(CFG_RATE_SCALE, {12'($urandom), 4'($urandom_range(1, 15))});
        write_reg(CFG_AW'($urandom_range(CFG_FIRST_UNUSED, CFG_INDEX_TOP)),
                  CFG_DW'($urandom_range(0, SAMPLE_TOP)));
    endtask

    initial begin
        clear_pulse_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: full-scale average with a long press (flat window), then zero, then
        // full scale again for a minimum bar and a full bar with a peak.
        for (int i = 0; i < AVG_LEN; i++)
            push_tick(FULL_SCALE, 1'b0);
        for (int i = 0; i < AVG_LEN; i++)
            push_tick('0, 1'b1);
        for (int i = 0; i < AVG_LEN; i++)
            push_tick(FULL_SCALE, 1'b1);
        drain_and_settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    // Zero threshold: a constant window has zero spread and is not flat.
                    write_reg(CFG_FLAT_THRESHOLD, '0);
                    write_reg(CFG_RISE_PERCENT, '0);
                    write_reg(CFG_FALL_PERCENT, 16'd100);
                    write_reg(CFG_RATE_SCALE, 16'd15);
                    push_segment(11, 30000, 0, 2, 0);
                    push_segment(14, 20000, 20000, 2, 50);
                end
                1: begin
                    // Largest threshold: only a full-scale spread counts as a signal.
                    write_reg(CFG_FLAT_THRESHOLD, 16'hffff);
                    write_reg(CFG_RISE_PERCENT, 16'd100);
                    write_reg(CFG_FALL_PERCENT, '0);
                    write_reg(CFG_RATE_SCALE, 16'd1);
                    push_segment(12, 0, SAMPLE_TOP, 2, 0);
                    push_noise(45);
                end
                2: begin
                    // Rise level above 100 percent never counts a peak.
                    write_reg(CFG_FLAT_THRESHOLD, CFG_DW'($urandom_range(0, 2000)));
                    write_reg(CFG_RISE_PERCENT, CFG_DW'($urandom_range(101, 127)));
                    write_reg(CFG_FALL_PERCENT, CFG_DW'($urandom_range(0, 100)));
                    write_reg(CFG_RATE_SCALE, CFG_DW'($urandom_range(1, 15)));
                    long_hold_req = 1'b1;
                    push_segment(24, 10000, $urandom_range(5000, 40000),
                                 $urandom_range(4, 12), 300);
                end
                default: begin
                    random_config();
                    if (ph == 7)
                        quiet_run = 1'b1;
                    push_segment(10, $urandom_range(0, 30000), $urandom_range(2000, 30000),
                                 $urandom_range(3, 14), $urandom_range(0, 800));
                    push_noise($urandom_range(3, 13));
                    push_segment(10, $urandom_range(0, 30000), $urandom_range(2000, 30000),
                                 $urandom_range(2, 14), $urandom_range(0, 800));
                end
            endcase
            drain_and_settle();
        end

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/prd_pkg.sv
src/prd_cmp.sv
src/prd_debounce.sv
src/pulse_rate_detector_top.sv
sim/tb.sv
